[src/xxf_pkg.sv]
// Shared types, codes and reset values for the XON/XOFF receive ring.
package xxf_pkg;

    localparam int RING_DEPTH_DEF = 256;

    localparam logic [7:0] XOFF_CODE = 8'h13;
    localparam logic [7:0] XON_CODE  = 8'h11;

    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    localparam logic [7:0] HIGH_MARK_RST     = 8'd179;
    localparam logic [7:0] LOW_MARK_RST      = 8'd50;
    localparam logic       UPCASE_ENABLE_RST = 1'b1;
    localparam logic [7:0] LINE_END_RST      = 8'h0D;

    localparam logic ACT_RECEIVE = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    localparam logic [1:0] FLOW_NONE = 2'd0;
    localparam logic [1:0] FLOW_XOFF = 2'd1;
    localparam logic [1:0] FLOW_XON  = 2'd2;

    typedef enum logic [1:0] {
        CFG_HIGH_MARK     = 2'd0,
        CFG_LOW_MARK      = 2'd1,
        CFG_UPCASE_ENABLE = 2'd2,
        CFG_LINE_END_CHAR = 2'd3
    } cfg_index_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } ctrl_state_t;

    typedef struct packed {
        logic [7:0] high_mark;
        logic [7:0] low_mark;
        logic       upcase_enable;
        logic [7:0] line_end_char;
    } cfg_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [1:0] flow_send;
        logic [7:0] read_data;
        logic       read_valid;
        logic       command_end;
        logic       partner_paused;
        logic [7:0] fill_level;
    } result_t;

endpackage

[src/xxf_ring_ram.sv]
// Byte ring storage: one write port and one registered read port.
module xxf_ring_ram #(
    parameter int DEPTH = xxf_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/xxf_cfg_regs.sv]
// Configuration registers with their reset values.
module xxf_cfg_regs (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    output xxf_pkg::cfg_t cfg
);

    xxf_pkg::cfg_t cfg_reg;
    xxf_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (xxf_pkg::cfg_index_t'(cfg_index))
                xxf_pkg::CFG_HIGH_MARK:     cfg_next.high_mark     = cfg_data;
                xxf_pkg::CFG_LOW_MARK:      cfg_next.low_mark      = cfg_data;
                xxf_pkg::CFG_UPCASE_ENABLE: cfg_next.upcase_enable = cfg_data[0];
                xxf_pkg::CFG_LINE_END_CHAR: cfg_next.line_end_char = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_mark     <= xxf_pkg::HIGH_MARK_RST;
            cfg_reg.low_mark      <= xxf_pkg::LOW_MARK_RST;
            cfg_reg.upcase_enable <= xxf_pkg::UPCASE_ENABLE_RST;
            cfg_reg.line_end_char <= xxf_pkg::LINE_END_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/xxf_flow_ctrl.sv]
// Ring pointers, flow-control flags, read sequencing and the result register.
module xxf_flow_ctrl #(
    parameter int DEPTH = xxf_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  xxf_pkg::cfg_t    cfg,
    input  logic             item_valid,
    output logic             item_stall,
    input  xxf_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output xxf_pkg::result_t result,
    output logic             ram_wr_en,
    output logic [AW-1:0]    ram_wr_addr,
    output logic [7:0]       ram_wr_data,
    output logic             ram_rd_en,
    output logic [AW-1:0]    ram_rd_addr,
    input  logic [7:0]       ram_rd_data
);

    localparam int CW = (AW > 8) ? AW : 8;
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [CW-1:0] fill_of(input logic [AW-1:0] wp,
                                              input logic [AW-1:0] rp);
        logic [AW:0] sum;
        sum = {1'b0, wp} + ((wp < rp) ? DEPTH_W : '0) - {1'b0, rp};
        fill_of = CW'(sum[AW-1:0]);
    endfunction

    xxf_pkg::ctrl_state_t state_reg, state_next;
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic              paused_reg, paused_next;
    logic              xoff_issued_reg, xoff_issued_next;
    logic              rd_hit_reg, rd_hit_next;
    logic              out_valid_reg, out_valid_next;
    xxf_pkg::result_t  result_reg, result_next;

    logic        accept;
    logic [7:0]  byte_up;
    logic        paused_now;
    logic        hi_hit;
    logic        xoff_mid;
    logic        lo_hit;
    logic [CW-1:0] fill_new;
    logic [CW-1:0] fill_cur;
    logic [CW-1:0] high_w;
    logic [CW-1:0] low_w;

    assign item_stall = (state_reg == xxf_pkg::ST_READ) || (out_valid_reg && result_stall);
    assign accept     = item_valid && !item_stall;

    assign high_w = CW'(cfg.high_mark);
    assign low_w  = CW'(cfg.low_mark);

    always_comb
    begin
        byte_up = item.rx_byte;
        if (cfg.upcase_enable && (item.rx_byte inside {[xxf_pkg::LOWER_A:xxf_pkg::LOWER_Z]}))
        begin
            byte_up = item.rx_byte - xxf_pkg::CASE_DELTA;
        end
    end

    assign ram_wr_en   = accept && (item.action == xxf_pkg::ACT_RECEIVE);
    assign ram_wr_addr = wr_ptr_reg;
    assign ram_wr_data = byte_up;
    assign ram_rd_en   = accept && (item.action == xxf_pkg::ACT_READ);
    assign ram_rd_addr = rd_ptr_reg;

    assign fill_cur = fill_of(wr_ptr_reg, rd_ptr_reg);

    always_comb
    begin
        state_next       = state_reg;
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        paused_next      = paused_reg;
        xoff_issued_next = xoff_issued_reg;
        rd_hit_next      = rd_hit_reg;
        result_next      = result_reg;
        out_valid_next   = out_valid_reg && result_stall;
        paused_now       = paused_reg || (byte_up == xxf_pkg::XOFF_CODE);
        fill_new         = fill_cur;
        hi_hit           = 1'b0;
        xoff_mid         = xoff_issued_reg;
        lo_hit           = 1'b0;

        case (state_reg)
            xxf_pkg::ST_IDLE:
            begin
                if (accept && (item.action == xxf_pkg::ACT_RECEIVE))
                begin
                    result_next = '0;
                    result_next.flow_send = xxf_pkg::FLOW_NONE;
                    if (paused_now)
                    begin
                        // The partner is paused: the byte is not kept and no mark is checked.
                        paused_next = (byte_up != xxf_pkg::XON_CODE);
                    end
                    else
                    begin
                        if (!xoff_issued_reg)
                        begin
                            wr_ptr_next = ptr_inc(wr_ptr_reg);
                            result_next.command_end = (byte_up == cfg.line_end_char);
                        end
                        fill_new = fill_of(wr_ptr_next, rd_ptr_reg);
                        hi_hit   = (fill_new > high_w) && !xoff_issued_reg;
                        xoff_mid = xoff_issued_reg || hi_hit;
                        lo_hit   = (fill_new < low_w) && xoff_mid;
                        // When both marks fire in one beat, XON wins and clears the flag.
                        xoff_issued_next = xoff_mid && !lo_hit;
                        if (lo_hit)
                        begin
                            result_next.flow_send = xxf_pkg::FLOW_XON;
                        end
                        else if (hi_hit)
                        begin
                            result_next.flow_send = xxf_pkg::FLOW_XOFF;
                        end
                    end
                    result_next.partner_paused = paused_next;
                    result_next.fill_level     = fill_new[7:0];
                    out_valid_next             = 1'b1;
                end
                else if (accept)
                begin
                    rd_hit_next = (rd_ptr_reg != wr_ptr_reg);
                    if (rd_ptr_reg != wr_ptr_reg)
                    begin
                        rd_ptr_next = ptr_inc(rd_ptr_reg);
                    end
                    state_next = xxf_pkg::ST_READ;
                end
            end
            xxf_pkg::ST_READ:
            begin
                // Ring data arrives in the cycle after the read beat was taken.
                result_next                = '0;
                result_next.flow_send      = xxf_pkg::FLOW_NONE;
                result_next.read_data      = rd_hit_reg ? ram_rd_data : 8'h00;
                result_next.read_valid     = rd_hit_reg;
                result_next.partner_paused = paused_reg;
                result_next.fill_level     = fill_cur[7:0];
                out_valid_next             = 1'b1;
                state_next                 = xxf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = xxf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= xxf_pkg::ST_IDLE;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            paused_reg      <= 1'b0;
            xoff_issued_reg <= 1'b0;
            rd_hit_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            paused_reg      <= paused_next;
            xoff_issued_reg <= xoff_issued_next;
            rd_hit_reg      <= rd_hit_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

[src/xon_xoff_receive_fifo_top.sv]
// Receive beat: result valid in the cycle after acceptance; one receive beat
// per cycle unless the result stalls. Read beat: data passes the ring's registered
// read port, then the result register; no beat is taken while in ST_READ.
// Reset (rst_n, asynchronous) clears pointers, flags and the result valid and
// loads the configuration defaults; ring contents are not cleared and need no pass.
module xon_xoff_receive_fifo_top #(
    parameter int RING_DEPTH = xxf_pkg::RING_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  xxf_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output xxf_pkg::result_t result,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);

    xxf_pkg::cfg_t cfg;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    xxf_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    xxf_ring_ram #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    xxf_flow_ctrl #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_flow_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

endmodule
